// ===== src/assert_macros.svh =====
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/uapq_pkg.sv =====
// Shared constants, codes and types for the unsorted array priority queue.
package uapq_pkg;

    localparam int CAPACITY = 64;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int COUNT_W  = $clog2(CAPACITY + 1);
    localparam int DATA_W   = 32;

    typedef enum logic [1:0] {
        OP_ENQ     = 2'd0,
        OP_DEQ_MIN = 2'd1,
        OP_DEQ_MAX = 2'd2,
        OP_NOP     = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_ENQUEUED = 2'd0,
        ST_DEQUEUED = 2'd1,
        ST_FULL     = 2'd2,
        ST_EMPTY    = 2'd3
    } t_status;

    // Scan token handed from cell to cell.
    typedef struct packed {
        logic signed [DATA_W-1:0] best_pri;
        logic signed [DATA_W-1:0] best_val;
        logic [IDX_W-1:0]         best_idx;
        logic signed [DATA_W-1:0] last_pri;
        logic signed [DATA_W-1:0] last_val;
    } t_tok;

    // Broadcast entry write.
    typedef struct packed {
        logic                     en;
        logic [IDX_W-1:0]         idx;
        logic signed [DATA_W-1:0] val;
        logic signed [DATA_W-1:0] pri;
    } t_wr;

endpackage

// ===== src/uapq_cell.sv =====
// One queue slot: holds an entry and updates the passing scan token.
module uapq_cell
    import uapq_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [IDX_W-1:0]   i_index,
    input  logic [COUNT_W-1:0] i_count,
    input  logic               i_want_small,
    input  t_wr                i_wr,
    input  logic               i_tok_vld,
    input  t_tok               i_tok,
    output logic               o_tok_vld,
    output t_tok               o_tok
);

    logic signed [DATA_W-1:0] r_val;
    logic signed [DATA_W-1:0] r_pri;
    logic                     r_tok_vld;
    t_tok                     r_tok;
    t_tok                     n_tok;
    logic                     w_held;
    logic                     w_last;
    logic                     w_better;

    always_comb begin
        w_held   = COUNT_W'(i_index) < i_count;
        w_last   = (COUNT_W'(i_index) + COUNT_W'(1)) == i_count;
        w_better = i_want_small ? ($signed(r_pri) < $signed(i_tok.best_pri))
                                : ($signed(r_pri) > $signed(i_tok.best_pri));
        n_tok    = i_tok;
        if (w_held) begin
            // strict compare: the earliest of equal priorities stays best
            if (i_index == '0 || w_better) begin
                n_tok.best_pri = r_pri;
                n_tok.best_val = r_val;
                n_tok.best_idx = i_index;
            end
            if (w_last) begin
                n_tok.last_pri = r_pri;
                n_tok.last_val = r_val;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.en && i_wr.idx == i_index) begin
            r_val <= i_wr.val;
            r_pri <= i_wr.pri;
        end
        if (i_tok_vld) begin
            r_tok <= n_tok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok_vld <= 1'b0;
        end else begin
            r_tok_vld <= i_tok_vld;
        end
    end

    assign o_tok_vld = r_tok_vld;
    assign o_tok     = r_tok;

endmodule

// ===== src/unsorted_array_priority_queue.sv =====
// Top level: transaction control and the row of entry cells.
//
//  channel | direction | handshake                    | payload
//  --------+-----------+------------------------------+--------------------------------------
//  in      | input     | i_in_valid / o_in_stall      | i_operation, i_item_value,
//          |           |                              | i_item_priority
//  out     | output    | o_out_valid / i_out_stall    | o_status, o_out_value,
//          |           |                              | o_out_priority, o_entry_count
//
// Enqueue, no-op and empty dequeue: the result is written to the output register at accept.
// Dequeue of a held entry: the scan token walks the cell row one cell per cycle, then
//   S_DONE moves the last entry into the freed slot and registers the result.
// One transaction is in work at a time; a new one is taken only when the output register
//   is empty or its result leaves in the same cycle.
// Reset (synchronous, active low) empties the queue; entry storage is not cleared.
// A stalled result holds in the output register and stalls the input; a dequeue always
//   starts with the output free, so its scan never waits.
`include "assert_macros.svh"

module unsorted_array_priority_queue
    import uapq_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic [1:0]               i_operation,
    input  logic signed [DATA_W-1:0] i_item_value,
    input  logic signed [DATA_W-1:0] i_item_priority,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic [1:0]               o_status,
    output logic signed [DATA_W-1:0] o_out_value,
    output logic signed [DATA_W-1:0] o_out_priority,
    output logic [COUNT_W-1:0]       o_entry_count
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_DONE = 3'b100
    } t_state;

    t_state                   r_state, n_state;
    logic [COUNT_W-1:0]       r_count, n_count;
    logic                     r_want_small, n_want_small;
    logic                     r_launch, n_launch;
    logic                     r_out_valid, n_out_valid;
    t_status                  r_status, n_status;
    logic signed [DATA_W-1:0] r_out_val, n_out_val;
    logic signed [DATA_W-1:0] r_out_pri, n_out_pri;
    logic [COUNT_W-1:0]       r_out_cnt, n_out_cnt;

    logic                     w_in_acc;
    logic                     w_out_take;
    t_wr                      w_wr;
    logic                     w_vld [0:CAPACITY];
    t_tok                     w_tok [0:CAPACITY];

    // Fresh token enters cell 0 the cycle after a dequeue is accepted.
    assign w_vld[0] = r_launch;
    assign w_tok[0] = '0;

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        uapq_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_index      (IDX_W'(g)),
            .i_count      (r_count),
            .i_want_small (r_want_small),
            .i_wr         (w_wr),
            .i_tok_vld    (w_vld[g]),
            .i_tok        (w_tok[g]),
            .o_tok_vld    (w_vld[g+1]),
            .o_tok        (w_tok[g+1])
        );
    end

    assign o_in_stall = !((r_state == S_IDLE) && (!r_out_valid || !i_out_stall));
    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign w_out_take = r_out_valid && !i_out_stall;

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_want_small = r_want_small;
        n_launch     = 1'b0;
        n_out_valid  = w_out_take ? 1'b0 : r_out_valid;
        n_status     = r_status;
        n_out_val    = r_out_val;
        n_out_pri    = r_out_pri;
        n_out_cnt    = r_out_cnt;
        w_wr         = '0;

        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    // default result: nothing removed, count unchanged
                    n_out_valid = 1'b1;
                    n_status    = ST_EMPTY;
                    n_out_val   = '0;
                    n_out_pri   = '0;
                    n_out_cnt   = r_count;
                    case (t_op'(i_operation))
                        OP_ENQ: begin
                            if (r_count < COUNT_W'(CAPACITY)) begin
                                w_wr.en   = 1'b1;
                                w_wr.idx  = r_count[IDX_W-1:0];
                                w_wr.val  = i_item_value;
                                w_wr.pri  = i_item_priority;
                                n_count   = r_count + COUNT_W'(1);
                                n_out_cnt = r_count + COUNT_W'(1);
                                n_status  = ST_ENQUEUED;
                            end else begin
                                n_status  = ST_FULL;
                            end
                        end
                        OP_DEQ_MIN, OP_DEQ_MAX: begin
                            if (r_count != '0) begin
                                n_out_valid  = r_out_valid && !w_out_take;
                                n_want_small = (t_op'(i_operation) == OP_DEQ_MIN);
                                n_launch     = 1'b1;
                                n_state      = S_SCAN;
                            end
                        end
                        default: begin
                            n_status = ST_EMPTY;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                if (w_vld[CAPACITY]) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                // last cell's token holds best and last entries until the next scan
                if (!r_out_valid || w_out_take) begin
                    w_wr.en     = 1'b1;
                    w_wr.idx    = w_tok[CAPACITY].best_idx;
                    w_wr.val    = w_tok[CAPACITY].last_val;
                    w_wr.pri    = w_tok[CAPACITY].last_pri;
                    n_count     = r_count - COUNT_W'(1);
                    n_out_valid = 1'b1;
                    n_status    = ST_DEQUEUED;
                    n_out_val   = w_tok[CAPACITY].best_val;
                    n_out_pri   = w_tok[CAPACITY].best_pri;
                    n_out_cnt   = r_count - COUNT_W'(1);
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_launch    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_launch    <= n_launch;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_want_small <= n_want_small;
        r_status     <= n_status;
        r_out_val    <= n_out_val;
        r_out_pri    <= n_out_pri;
        r_out_cnt    <= n_out_cnt;
    end

    assign o_out_valid    = r_out_valid;
    assign o_status       = r_status;
    assign o_out_value    = r_out_val;
    assign o_out_priority = r_out_pri;
    assign o_entry_count  = r_out_cnt;

    `ASSERT_NOW(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= COUNT_W'(CAPACITY),
        "entry count above capacity")
    `ASSERT_NOW(a_tok_in_scan, i_clk, i_rst_n, w_vld[CAPACITY], r_state == S_SCAN,
        "scan token left the row outside a scan")
    `ASSERT_NEXT(a_deq_starts_scan, i_clk, i_rst_n,
        w_in_acc && r_count != '0 && (i_operation == OP_DEQ_MIN || i_operation == OP_DEQ_MAX),
        r_state == S_SCAN && r_launch, "dequeue did not start a scan")
    `ASSERT_NOW(a_best_held, i_clk, i_rst_n, r_state == S_DONE,
        COUNT_W'(w_tok[CAPACITY].best_idx) < r_count, "selected entry not held")

endmodule

// ===== tb/sv/unsorted_array_priority_queue_tb.sv =====
// Self-checking testbench for the unsorted array priority queue.
`timescale 1ns / 100ps

module unsorted_array_priority_queue_tb;
    import uapq_pkg::*;

    // Covers a dequeue of a held entry, with a little slack on top.
    localparam int DRAIN_CYCLES    = CAPACITY + 8;
    // Longest legal stretch without any transaction: receiver hold-off plus a full
    // scan plus random gaps on both sides, taken several times over.
    localparam int HOLDOFF_CYCLES  = 300;
    localparam int WATCHDOG_LIMIT  = 4000;
    // Minimum counted (non no-op) random transactions per idling phase, three phases.
    localparam int RAND_PER_PHASE  = 570;
    localparam int MAX_PRINTED     = 200;

    // One result as seen on the output channel.
    typedef struct packed {
        t_status              st;
        logic [DATA_W-1:0]    val;
        logic [DATA_W-1:0]    pri;
        logic [COUNT_W-1:0]   cnt;
    } t_result;

    // One row of the directed table. Rows with rep > 1 send random payloads.
    typedef struct {
        t_op                  op;
        logic [DATA_W-1:0]    val;
        logic [DATA_W-1:0]    pri;
        int                   rep;
        bit                   fixed;
        t_result              want;
    } t_row;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n;
    logic                     i_in_valid;
    logic                     o_in_stall;
    logic [1:0]               i_operation;
    logic signed [DATA_W-1:0] i_item_value;
    logic signed [DATA_W-1:0] i_item_priority;
    logic                     o_out_valid;
    logic                     i_out_stall;
    logic [1:0]               o_status;
    logic signed [DATA_W-1:0] o_out_value;
    logic signed [DATA_W-1:0] o_out_priority;
    logic [COUNT_W-1:0]       o_entry_count;

    // Shadow copy of the queue contents, updated on every accepted input transaction.
    logic signed [DATA_W-1:0] shadow_val [CAPACITY];
    logic signed [DATA_W-1:0] shadow_pri [CAPACITY];
    int                       shadow_held;

    // Results still owed by the block, oldest first.
    t_result                  pending_results [$];
    t_row                     dir_rows [$];

    int                       mismatch_count = 0;
    int                       idle_cycles    = 0;
    int unsigned              send_idle_pct  = 0;
    int unsigned              recv_stall_pct = 0;
    int                       holdoff_req    = 0;
    int                       holdoff_left   = 0;

    unsorted_array_priority_queue uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_operation     (i_operation),
        .i_item_value    (i_item_value),
        .i_item_priority (i_item_priority),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_status        (o_status),
        .o_out_value     (o_out_value),
        .o_out_priority  (o_out_priority),
        .o_entry_count   (o_entry_count)
    );

    // 20 ns period
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Apply one operation to the shadow queue and return the result the block owes.
    // Dequeue scans from the front with a strict signed compare, so the first of
    // equal priorities wins; the last entry then fills the freed slot.
    function automatic t_result apply_to_shadow_queue(t_op op, logic [DATA_W-1:0] v,
                                                      logic [DATA_W-1:0] p);
        t_result r;
        int      best;
        int      last;
        r = '0;
        case (op)
            OP_ENQ: begin
                if (shadow_held >= CAPACITY) begin
                    r.st = ST_FULL;
                end else begin
                    shadow_val[shadow_held] = v;
                    shadow_pri[shadow_held] = p;
                    shadow_held++;
                    r.st = ST_ENQUEUED;
                end
            end
            OP_DEQ_MIN, OP_DEQ_MAX: begin
                if (shadow_held == 0) begin
                    r.st = ST_EMPTY;
                end else begin
                    best = 0;
                    for (int i = 1; i < shadow_held; i++) begin
                        if (op == OP_DEQ_MIN ? (shadow_pri[i] < shadow_pri[best])
                                             : (shadow_pri[i] > shadow_pri[best]))
                            best = i;
                    end
                    r.st  = ST_DEQUEUED;
                    r.val = shadow_val[best];
                    r.pri = shadow_pri[best];
                    last  = shadow_held - 1;
                    shadow_val[best] = shadow_val[last];
                    shadow_pri[best] = shadow_pri[last];
                    shadow_held = last;
                end
            end
            default: begin
                // no-op code: nothing changes, reported as empty
                r.st = ST_EMPTY;
            end
        endcase
        r.cnt = COUNT_W'(shadow_held);
        return r;
    endfunction

    function automatic t_row mk_row(t_op op, logic [DATA_W-1:0] v, logic [DATA_W-1:0] p,
                                    int rep, bit fixed, t_status st,
                                    logic [DATA_W-1:0] wv, logic [DATA_W-1:0] wp, int wc);
        t_row row;
        row.op       = op;
        row.val      = v;
        row.pri      = p;
        row.rep      = rep;
        row.fixed    = fixed;
        row.want.st  = st;
        row.want.val = wv;
        row.want.pri = wp;
        row.want.cnt = COUNT_W'(wc);
        return row;
    endfunction

    // Print is capped to keep the log short; every mismatch is still counted.
    task automatic report_mismatch(string what, logic [DATA_W-1:0] got,
                                   logic [DATA_W-1:0] want);
        if (mismatch_count < MAX_PRINTED)
            $display("%0t: mismatch on %s: got %0h, expected %0h", $realtime, what, got,
                     want);
        mismatch_count++;
    endtask

    // Offer one input transaction. Entered and left just after a falling edge.
    // With use_given set, the typed-in result replaces the prediction, but the
    // shadow queue still takes the operation so it stays in step with the block.
    task automatic send_txn(t_op op, logic [DATA_W-1:0] v, logic [DATA_W-1:0] p,
                            bit use_given, t_result given);
        t_result predicted;
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_operation     <= op;
        i_item_value    <= v;
        i_item_priority <= p;
        do @(posedge i_clk); while (o_in_stall);
        predicted = apply_to_shadow_queue(op, v, p);
        pending_results.push_back(use_given ? given : predicted);
        @(negedge i_clk);
    endtask

    // Sender pause: stop offering and wait for every owed result.
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Receiver side: random stall at the phase's rate, or a long hold-off on request.
    // The hold-off is counted here so the sender keeps pushing while the block backs up.
    always @(negedge i_clk) begin
        if (holdoff_req > 0) begin
            holdoff_left = holdoff_req;
            holdoff_req  = 0;
        end
        if (holdoff_left > 0) begin
            holdoff_left--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // Result checker: every accepted output transaction against the oldest expectation.
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                report_mismatch("result with nothing pending", DATA_W'(o_status), '0);
            end else begin
                want = pending_results.pop_front();
                if (o_status !== want.st)
                    report_mismatch("status", DATA_W'(o_status), DATA_W'(want.st));
                if (o_out_value !== want.val)
                    report_mismatch("out_value", o_out_value, want.val);
                if (o_out_priority !== want.pri)
                    report_mismatch("out_priority", o_out_priority, want.pri);
                if (o_entry_count !== want.cnt)
                    report_mismatch("entry_count", DATA_W'(o_entry_count),
                                    DATA_W'(want.cnt));
            end
        end
    end

    // Watchdog: any transaction on either channel restarts the count.
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $realtime, idle_cycles);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        logic [DATA_W-1:0] v;
        logic [DATA_W-1:0] p;
        t_op               op;
        int                counted;
        int                seg_len;
        int unsigned       enq_pct;
        int unsigned       roll;
        bit                holdoff_done;

        i_rst_n         = 1'b0;
        i_in_valid      = 1'b0;
        i_operation     = OP_NOP;
        i_item_value    = '0;
        i_item_priority = '0;
        i_out_stall     = 1'b0;
        shadow_held     = 0;
        holdoff_done    = 1'b0;

        // Directed table. Typed-in results are the obvious ones: empty/no-op
        // replies, extremes of the priority range, and the full replies.
        // Entries enqueued below: (7fffffff,min) (80000000,max) (0,0) (-1,max) (5,min)
        // so both dequeue directions see a tie and the first holder must win.
        dir_rows.push_back(mk_row(OP_DEQ_MIN, 32'h0, 32'h0, 1, 1,
                                  ST_EMPTY, 32'h0, 32'h0, 0));
        dir_rows.push_back(mk_row(OP_DEQ_MAX, 32'h1234, 32'h5678, 1, 1,
                                  ST_EMPTY, 32'h0, 32'h0, 0));
        dir_rows.push_back(mk_row(OP_NOP, 32'hffff_ffff, 32'hffff_ffff, 1, 1,
                                  ST_EMPTY, 32'h0, 32'h0, 0));
        dir_rows.push_back(mk_row(OP_ENQ, 32'h7fff_ffff, 32'h8000_0000, 1, 1,
                                  ST_ENQUEUED, 32'h0, 32'h0, 1));
        dir_rows.push_back(mk_row(OP_ENQ, 32'h8000_0000, 32'h7fff_ffff, 1, 1,
                                  ST_ENQUEUED, 32'h0, 32'h0, 2));
        dir_rows.push_back(mk_row(OP_ENQ, 32'h0, 32'h0, 1, 1,
                                  ST_ENQUEUED, 32'h0, 32'h0, 3));
        dir_rows.push_back(mk_row(OP_ENQ, 32'hffff_ffff, 32'h7fff_ffff, 1, 1,
                                  ST_ENQUEUED, 32'h0, 32'h0, 4));
        dir_rows.push_back(mk_row(OP_ENQ, 32'h5, 32'h8000_0000, 1, 1,
                                  ST_ENQUEUED, 32'h0, 32'h0, 5));
        // no-op with entries held still answers empty and keeps the count
        dir_rows.push_back(mk_row(OP_NOP, 32'ha5a5_a5a5, 32'h5a5a_5a5a, 1, 1,
                                  ST_EMPTY, 32'h0, 32'h0, 5));
        dir_rows.push_back(mk_row(OP_DEQ_MAX, 32'h0, 32'h0, 1, 1,
                                  ST_DEQUEUED, 32'h8000_0000, 32'h7fff_ffff, 4));
        dir_rows.push_back(mk_row(OP_DEQ_MIN, 32'h0, 32'h0, 1, 1,
                                  ST_DEQUEUED, 32'h7fff_ffff, 32'h8000_0000, 3));
        dir_rows.push_back(mk_row(OP_DEQ_MIN, 32'h0, 32'h0, 1, 1,
                                  ST_DEQUEUED, 32'h5, 32'h8000_0000, 2));
        dir_rows.push_back(mk_row(OP_DEQ_MAX, 32'h0, 32'h0, 1, 1,
                                  ST_DEQUEUED, 32'hffff_ffff, 32'h7fff_ffff, 1));
        dir_rows.push_back(mk_row(OP_DEQ_MIN, 32'h0, 32'h0, 1, 1,
                                  ST_DEQUEUED, 32'h0, 32'h0, 0));
        dir_rows.push_back(mk_row(OP_DEQ_MAX, 32'hdead_beef, 32'h0, 1, 1,
                                  ST_EMPTY, 32'h0, 32'h0, 0));
        // fill to capacity with random entries, then overflow twice
        dir_rows.push_back(mk_row(OP_ENQ, 32'h0, 32'h0, CAPACITY, 0,
                                  ST_ENQUEUED, 32'h0, 32'h0, 0));
        dir_rows.push_back(mk_row(OP_ENQ, 32'h7fff_ffff, 32'h7fff_ffff, 1, 1,
                                  ST_FULL, 32'h0, 32'h0, CAPACITY));
        dir_rows.push_back(mk_row(OP_ENQ, 32'h8000_0000, 32'h8000_0000, 1, 1,
                                  ST_FULL, 32'h0, 32'h0, CAPACITY));
        // dequeues from a full array scan every slot
        dir_rows.push_back(mk_row(OP_DEQ_MIN, 32'h0, 32'h0, 1, 0,
                                  ST_DEQUEUED, 32'h0, 32'h0, 0));
        dir_rows.push_back(mk_row(OP_DEQ_MAX, 32'h0, 32'h0, 1, 0,
                                  ST_DEQUEUED, 32'h0, 32'h0, 0));

        // Synchronous reset held from the start, released on a falling edge.
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        send_idle_pct  = 33;
        recv_stall_pct = 47;
        foreach (dir_rows[r]) begin
            for (int k = 0; k < dir_rows[r].rep; k++) begin
                send_txn(dir_rows[r].op,
                         dir_rows[r].rep > 1 ? DATA_W'($urandom) : dir_rows[r].val,
                         dir_rows[r].rep > 1 ? DATA_W'($urandom) : dir_rows[r].pri,
                         dir_rows[r].fixed, dir_rows[r].want);
            end
        end

        // Random part in three idling phases. Segments swing the enqueue share
        // between heavy, balanced and light so the fill level sweeps from empty
        // to full and back, with many priority ties from a narrow range.
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct  = 33;
                    recv_stall_pct = 47;
                end
                1: begin
                    send_idle_pct  = 47;
                    recv_stall_pct = 33;
                end
                default: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
            endcase
            counted = 0;
            while (counted < RAND_PER_PHASE) begin
                seg_len = $urandom_range(80, 20);
                case ($urandom_range(2))
                    0:       enq_pct = 90;
                    1:       enq_pct = 50;
                    default: enq_pct = 12;
                endcase
                for (int k = 0; k < seg_len; k++) begin
                    v    = $urandom;
                    roll = $urandom_range(9);
                    if (roll < 5)
                        p = DATA_W'($urandom_range(7)) - DATA_W'(4);
                    else if (roll < 6)
                        p = $urandom_range(1) ? 32'h8000_0000 : 32'h7fff_ffff;
                    else
                        p = $urandom;
                    if ($urandom_range(99) < 3) begin
                        op = OP_NOP;
                    end else begin
                        if ($urandom_range(99) < enq_pct)
                            op = OP_ENQ;
                        else
                            op = $urandom_range(1) ? OP_DEQ_MIN : OP_DEQ_MAX;
                        counted++;
                    end
                    send_txn(op, v, p, 1'b0, '0);
                    // Long receiver hold-off while the sender keeps offering,
                    // so the block backs up and stalls its input.
                    if (phase == 0 && counted >= 150 && !holdoff_done) begin
                        holdoff_req  = HOLDOFF_CYCLES;
                        holdoff_done = 1'b1;
                    end
                end
            end
            // sender pause until every result is in
            wait_drained();
        end

        // Let any stray late result show up before the verdict.
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+src
src/uapq_pkg.sv
src/uapq_cell.sv
src/unsorted_array_priority_queue.sv
tb/sv/unsorted_array_priority_queue_tb.sv
